// File: rtl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// Field widths, status and register codes, and the controller/datapath structs.
// No dependencies; every other file takes names from here by scope.
package bba_pkg;

   // Field and register widths.
   localparam int ADDR_W      = 32;
   localparam int BSIZE_W     = 13;
   localparam int BCOUNT_W    = 8;
   localparam int SIZE_W      = 16;
   localparam int STATUS_W    = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Divider sizing: the quotient is a block index below block_count.
   localparam int QUOT_W = BCOUNT_W;
   localparam int REM_W  = BSIZE_W + BCOUNT_W;
   localparam int DCNT_W = 3;

   // The free search looks at this many map bits per cycle.
   localparam int SCAN_W    = 16;
   localparam int SCAN_BITS = 4;

   // Operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_COUNT = 2'd2;

   // Register reset values.
   localparam logic [ADDR_W-1:0]   RST_POOL_BASE   = 32'd0;
   localparam logic [BSIZE_W-1:0]  RST_BLOCK_SIZE  = 13'd8;
   localparam logic [BCOUNT_W-1:0] RST_BLOCK_COUNT = 8'd128;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK            = 3'd0,
      ST_SIZE_MISMATCH = 3'd1,
      ST_POOL_FULL     = 3'd2,
      ST_NOT_IN_POOL   = 3'd3,
      ST_NOT_ALLOCATED = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       prep;
      logic       scan_start;
      logic       scan_step;
      logic       take_block;
      logic       addr_mul;
      logic       addr_add;
      logic       div_start;
      logic       div_step;
      logic       free_block;
      logic       out_load;
      status_type out_status;
   } bba_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_free;
      logic size_match;
      logic in_pool;
      logic chunk_hit;
      logic chunk_last;
      logic div_last;
      logic block_used;
   } bba_stat_type;

endpackage

// File: rtl/bba_req_if.sv
// Request channel of the bitmap block allocator: valid, ready and request payload.
// Depends on bba_pkg for field widths.
interface bba_req_if;
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [bba_pkg::SIZE_W-1:0]  request_size;
   logic [bba_pkg::ADDR_W-1:0]  free_address;

   modport source (output valid, output opcode, output request_size,
                   output free_address, input ready);
   modport sink (input valid, input opcode, input request_size,
                 input free_address, output ready);
endinterface

// File: rtl/bba_rsp_if.sv
// Response channel of the bitmap block allocator: valid, ready and result payload.
// Depends on bba_pkg for field widths.
interface bba_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bba_pkg::ADDR_W-1:0]   block_address;
   logic [bba_pkg::STATUS_W-1:0] status;

   modport source (output valid, output block_address, output status, input ready);
   modport sink (input valid, input block_address, input status, output ready);
endinterface

// File: rtl/bba_datapath.sv
// Datapath of the bitmap block allocator: configuration registers, used map,
// chunked free-block search, address multiply, serial divider and result register.
// Depends on bba_pkg; driven by bba_ctrl through command and status structs.
module bba_datapath #(
   parameter int MAX_BLOCKS = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bba_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_opcode,
   input  logic [bba_pkg::SIZE_W-1:0]        req_request_size,
   input  logic [bba_pkg::ADDR_W-1:0]        req_free_address,
   output logic [bba_pkg::ADDR_W-1:0]        rsp_block_address,
   output logic [bba_pkg::STATUS_W-1:0]      rsp_status,
   input  bba_pkg::bba_cmd_type              cmd,
   output bba_pkg::bba_stat_type             stat
);

   localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int NCHUNK  = (MAX_BLOCKS + bba_pkg::SCAN_W - 1) / bba_pkg::SCAN_W;
   localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int PAD_W   = (1 << CHUNK_W) * bba_pkg::SCAN_W;
   localparam int GIX_W   = CHUNK_W + bba_pkg::SCAN_BITS;
   localparam int CMP_W   = GIX_W + bba_pkg::BCOUNT_W;
   localparam int MUL_W   = GIX_W + bba_pkg::BSIZE_W;
   localparam int QX_W    = IDX_W + bba_pkg::QUOT_W;
   localparam int CLAMP   = (MAX_BLOCKS < 255) ? MAX_BLOCKS : 255;

   // Configuration registers.
   logic [bba_pkg::ADDR_W-1:0]   pool_base_ff;
   logic [bba_pkg::BSIZE_W-1:0]  block_size_ff;
   logic [bba_pkg::BCOUNT_W-1:0] block_count_ff;

   // Used map, one flip-flop per block.
   logic [MAX_BLOCKS-1:0] used_ff;

   // Request and working registers.
   logic                         opcode_ff;
   logic [bba_pkg::SIZE_W-1:0]   size_ff;
   logic [bba_pkg::ADDR_W-1:0]   addr_ff;
   logic [bba_pkg::BCOUNT_W-1:0] n_ff;
   logic [bba_pkg::BCOUNT_W-1:0] n_in;
   logic                         size_match_ff;
   logic                         below_ff;
   logic [bba_pkg::ADDR_W-1:0]   offset_ff;
   logic [bba_pkg::REM_W-1:0]    extent_ff;
   logic [CHUNK_W-1:0]           chunk_ff;
   logic [GIX_W-1:0]             found_ff;
   logic [MUL_W-1:0]             mul_ff;
   logic [bba_pkg::ADDR_W-1:0]   res_addr_ff;
   logic [bba_pkg::REM_W-1:0]    rem_ff;
   logic [bba_pkg::REM_W-1:0]    rem_in;
   logic [bba_pkg::REM_W-1:0]    dsr_ff;
   logic [bba_pkg::QUOT_W-1:0]   quot_ff;
   logic [bba_pkg::QUOT_W-1:0]   quot_in;
   logic [bba_pkg::DCNT_W-1:0]   dcnt_ff;
   logic [bba_pkg::ADDR_W-1:0]   rsp_addr_ff;
   bba_pkg::status_type          rsp_status_ff;

   // Search and index signals.
   logic [PAD_W-1:0]                 map_pad;
   logic [bba_pkg::SCAN_W-1:0]       chunk_bits;
   logic [bba_pkg::SCAN_W-1:0]       elig;
   logic                             hit;
   logic [bba_pkg::SCAN_BITS-1:0]    hit_pos;
   logic [GIX_W-1:0]                 hit_idx;
   logic [QX_W-1:0]                  quot_ext;
   logic [IDX_W-1:0]                 free_idx;
   logic [IDX_W-1:0]                 take_idx;
   logic                             rem_ge;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= bba_pkg::RST_POOL_BASE;
         block_size_ff  <= bba_pkg::RST_BLOCK_SIZE;
         block_count_ff <= bba_pkg::RST_BLOCK_COUNT;
      end else if (csr_we) begin
         case (csr_index)
            bba_pkg::CSR_POOL_BASE: begin
               pool_base_ff <= csr_wdata;
            end
            bba_pkg::CSR_BLOCK_SIZE: begin
               block_size_ff <= csr_wdata[bba_pkg::BSIZE_W-1:0];
            end
            bba_pkg::CSR_BLOCK_COUNT: begin
               block_count_ff <= csr_wdata[bba_pkg::BCOUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Block count limited to the built capacity.
   always_comb begin
      if (block_count_ff > bba_pkg::BCOUNT_W'(CLAMP)) begin
         n_in = bba_pkg::BCOUNT_W'(CLAMP);
      end else begin
         n_in = block_count_ff;
      end
   end

   // One chunk of the map per cycle; padding and blocks past the count look used.
   always_comb begin
      map_pad = '1;
      map_pad[MAX_BLOCKS-1:0] = used_ff;
      chunk_bits = map_pad[chunk_ff*bba_pkg::SCAN_W +: bba_pkg::SCAN_W];
      for (int j = 0; j < bba_pkg::SCAN_W; j++) begin
         elig[j] = !chunk_bits[j] &&
                   (CMP_W'({chunk_ff, bba_pkg::SCAN_BITS'(j)}) < CMP_W'(n_ff));
      end
      hit     = 1'b0;
      hit_pos = '0;
      for (int j = bba_pkg::SCAN_W - 1; j >= 0; j--) begin
         if (elig[j]) begin
            hit     = 1'b1;
            hit_pos = bba_pkg::SCAN_BITS'(j);
         end
      end
      hit_idx  = {chunk_ff, hit_pos};
      take_idx = hit_idx[IDX_W-1:0];
   end

   // One restoring division step per cycle, most significant quotient bit first.
   always_comb begin
      rem_ge  = (rem_ff >= dsr_ff);
      rem_in  = rem_ge ? (rem_ff - dsr_ff) : rem_ff;
      quot_in = {quot_ff[bba_pkg::QUOT_W-2:0], rem_ge};
      quot_ext = QX_W'(quot_ff);
      free_idx = quot_ext[IDX_W-1:0];
   end

   // Used map updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.take_block) begin
         used_ff[take_idx] <= 1'b1;
      end else if (cmd.free_block) begin
         used_ff[free_idx] <= 1'b0;
      end
   end

   // Working registers, stepped by the controller.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opcode_ff   <= req_opcode;
         size_ff     <= req_request_size;
         addr_ff     <= req_free_address;
         n_ff        <= n_in;
         res_addr_ff <= '0;
      end
      if (cmd.prep) begin
         size_match_ff <= (size_ff == bba_pkg::SIZE_W'(block_size_ff));
         below_ff      <= (addr_ff < pool_base_ff);
         offset_ff     <= addr_ff - pool_base_ff;
         extent_ff     <= bba_pkg::REM_W'(block_size_ff) * bba_pkg::REM_W'(n_ff);
      end
      if (cmd.scan_start) begin
         chunk_ff <= '0;
      end else if (cmd.scan_step) begin
         chunk_ff <= chunk_ff + CHUNK_W'(1);
      end
      if (cmd.take_block) begin
         found_ff <= hit_idx;
      end
      if (cmd.addr_mul) begin
         mul_ff <= MUL_W'(found_ff) * MUL_W'(block_size_ff);
      end
      if (cmd.addr_add) begin
         res_addr_ff <= pool_base_ff + bba_pkg::ADDR_W'(mul_ff);
      end
      if (cmd.div_start) begin
         rem_ff  <= bba_pkg::REM_W'(offset_ff);
         dsr_ff  <= bba_pkg::REM_W'(block_size_ff) << (bba_pkg::QUOT_W - 1);
         quot_ff <= '0;
         dcnt_ff <= bba_pkg::DCNT_W'(bba_pkg::QUOT_W - 1);
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         dsr_ff  <= dsr_ff >> 1;
         quot_ff <= quot_in;
         dcnt_ff <= dcnt_ff - bba_pkg::DCNT_W'(1);
      end
      if (cmd.out_load) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= cmd.out_status;
      end
   end

   // Status back to the controller.
   always_comb begin
      stat.is_free    = (opcode_ff == bba_pkg::OP_FREE);
      stat.size_match = size_match_ff;
      stat.in_pool    = !below_ff && (offset_ff < bba_pkg::ADDR_W'(extent_ff));
      stat.chunk_hit  = hit;
      stat.chunk_last = (chunk_ff == CHUNK_W'(NCHUNK - 1));
      stat.div_last   = (dcnt_ff == '0);
      stat.block_used = used_ff[free_idx];
   end

   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

   // A taken block is marked used on the next cycle.
   a_take_sets: assert property (@(posedge clock) disable iff (reset)
      cmd.take_block |=> used_ff[found_ff[IDX_W-1:0]])
      else $error("taken block not marked used");

   // A released block reads free on the next cycle.
   a_free_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.free_block |=> !used_ff[free_idx])
      else $error("released block still marked used");

   // The search never hands out a block past the active count.
   a_take_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.take_block |-> (CMP_W'(hit_idx) < CMP_W'(n_ff)))
      else $error("allocated block index beyond block count");

endmodule

// File: rtl/bba_ctrl.sv
// Controller of the bitmap block allocator: sequences one request at a time
// through the datapath and owns the request and response handshakes.
// Depends on bba_pkg for the command and status structs.
module bba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bba_pkg::bba_cmd_type  cmd,
   input  bba_pkg::bba_stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_DECIDE,
      S_SCAN,
      S_MUL,
      S_ADD,
      S_DIV,
      S_RELEASE,
      S_REPLY
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   bba_pkg::status_type code_ff;
   bba_pkg::status_type code_in;
   logic                rsp_valid_ff;
   logic                out_free;

   // Next state and commands.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      code_in  = code_ff;
      out_free = !rsp_valid_ff || rsp_ready;
      cmd.out_status = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!stat.is_free) begin
               if (!stat.size_match) begin
                  code_in  = bba_pkg::ST_SIZE_MISMATCH;
                  state_in = S_REPLY;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in = S_SCAN;
               end
            end else begin
               if (!stat.in_pool) begin
                  code_in  = bba_pkg::ST_NOT_IN_POOL;
                  state_in = S_REPLY;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_SCAN: begin
            if (stat.chunk_hit) begin
               cmd.take_block = 1'b1;
               state_in = S_MUL;
            end else if (stat.chunk_last) begin
               code_in  = bba_pkg::ST_POOL_FULL;
               state_in = S_REPLY;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_MUL: begin
            cmd.addr_mul = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.addr_add = 1'b1;
            code_in  = bba_pkg::ST_OK;
            state_in = S_REPLY;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_RELEASE;
            end
         end
         S_RELEASE: begin
            if (stat.block_used) begin
               cmd.free_block = 1'b1;
               code_in = bba_pkg::ST_OK;
            end else begin
               code_in = bba_pkg::ST_NOT_ALLOCATED;
            end
            state_in = S_REPLY;
         end
         S_REPLY: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, status code and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         code_ff      <= bba_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         if (state_ff == S_REPLY && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // A response only appears out of the reply state.
   a_valid_from_reply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_REPLY))
      else $error("response raised outside the reply state");

   // A finished result waits while the output register is still held.
   a_reply_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLY && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_REPLY))
      else $error("result overwrote a response not yet taken");

endmodule

// File: rtl/bitmap_block_allocator_top.sv
// Bitmap block allocator. One request at a time; the response sits in an output register.
// Request to response valid: an allocate or a pool-full reply is paced by the
// 16-bit-per-cycle map search, a free by the one-bit-per-cycle divider; size mismatch
// and not in pool replies use neither.
// A new request can be accepted in the cycle after the previous response is loaded.
// Synchronous reset restores the configuration registers to defaults and clears the used map at once.
module bitmap_block_allocator_top #(
   parameter int MAX_BLOCKS = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   bba_req_if.sink                         req_ch,
   bba_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [bba_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bba_pkg::bba_cmd_type  cmd;
   bba_pkg::bba_stat_type stat;

   // Sequencer.
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Map, registers and arithmetic.
   bba_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_opcode        (req_ch.opcode),
      .req_request_size  (req_ch.request_size),
      .req_free_address  (req_ch.free_address),
      .rsp_block_address (rsp_ch.block_address),
      .rsp_status        (rsp_ch.status),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule

// File: tb/bitmap_block_allocator_top_tb.sv
// Self-checking testbench for bitmap_block_allocator_top: a directed stimulus table,
// then random register settings with alloc/free traffic checked against a used-map predictor.
// Depends on bba_pkg, bba_req_if and bba_rsp_if from the RTL.
module bitmap_block_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD    = 8;
   localparam int POOL_CAP      = 128;
   localparam int CYCLE_LIMIT   = 400000;
   // Longest request latency plus margin.
   localparam int SETTLE_CYCLES = 24;
   // Index with no register behind it.
   localparam logic [bba_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [bba_pkg::ADDR_W-1:0] block_address;
      bba_pkg::status_type        status;
   } alloc_reply_type;

   // One row of the directed table: either a register write or a request beat.
   typedef struct {
      logic                            is_write;
      logic [bba_pkg::CSR_INDEX_W-1:0] reg_index;
      logic [bba_pkg::CSR_DATA_W-1:0]  reg_value;
      logic                            opcode;
      logic [bba_pkg::SIZE_W-1:0]      request_size;
      logic [bba_pkg::ADDR_W-1:0]      free_address;
      logic                            typed;
      alloc_reply_type                 reply;
   } script_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [bba_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bba_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   bba_req_if req_if ();
   bba_rsp_if rsp_if ();

   // Mirror of the block's registers and used map.
   logic [bba_pkg::ADDR_W-1:0]   cfg_base;
   logic [bba_pkg::BSIZE_W-1:0]  cfg_block_size;
   logic [bba_pkg::BCOUNT_W-1:0] cfg_block_count;
   logic                         block_taken [POOL_CAP];

   alloc_reply_type pending_replies [$];
   script_row_type  script [$];

   int error_count = 0;
   int cycle_count = 0;
   int hold_left = 0;
   int requests_sent = 0;
   int settings_seen = 0;
   int status_tally [5] = '{default: 0};
   bit sender_gaps = 1'b1;
   bit receiver_stalls = 1'b1;
   bit hold_start = 1'b0;
   bit hold_seen = 1'b0;

   bitmap_block_allocator_top #(
      .MAX_BLOCKS(POOL_CAP)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_if),
      .rsp_ch   (rsp_if),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bitmap_block_allocator_top regression: fail");
         $finish;
      end
   end

   function automatic int active_blocks();
      return (cfg_block_count > POOL_CAP) ? POOL_CAP : int'(cfg_block_count);
   endfunction

   // Applies one request to the mirrored map and returns the reply it should produce.
   function automatic alloc_reply_type predict_reply(logic op,
                                                     logic [bba_pkg::SIZE_W-1:0] size,
                                                     logic [bba_pkg::ADDR_W-1:0] addr);
      alloc_reply_type r;
      int              n;
      int              idx;
      bit              found;
      logic [63:0]     extent;
      logic [63:0]     offset;
      r.block_address = '0;
      n = active_blocks();
      found = 1'b0;
      if (op == bba_pkg::OP_ALLOC) begin
         if (size != cfg_block_size) begin
            r.status = bba_pkg::ST_SIZE_MISMATCH;
         end else begin
            // Lowest free block among the active ones.
            r.status = bba_pkg::ST_POOL_FULL;
            for (int i = 0; i < n; i++) begin
               if (!found && !block_taken[i]) begin
                  block_taken[i] = 1'b1;
                  r.block_address = cfg_base + bba_pkg::ADDR_W'(i) *
                                    bba_pkg::ADDR_W'(cfg_block_size);
                  r.status = bba_pkg::ST_OK;
                  found = 1'b1;
               end
            end
         end
      end else begin
         // The pool range is checked without wrapping around the address space.
         extent = 64'(cfg_block_size) * 64'(n);
         offset = 64'(addr) - 64'(cfg_base);
         if (addr < cfg_base || offset >= extent) begin
            r.status = bba_pkg::ST_NOT_IN_POOL;
         end else begin
            idx = int'(offset / 64'(cfg_block_size));
            if (idx >= POOL_CAP) begin
               r.status = bba_pkg::ST_NOT_IN_POOL;
            end else if (block_taken[idx]) begin
               block_taken[idx] = 1'b0;
               r.status = bba_pkg::ST_OK;
            end else begin
               r.status = bba_pkg::ST_NOT_ALLOCATED;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
   endtask

   // Register write; the mirror follows at once since the block is idle.
   task automatic write_reg(logic [bba_pkg::CSR_INDEX_W-1:0] idx,
                            logic [bba_pkg::CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         bba_pkg::CSR_POOL_BASE:   cfg_base = value;
         bba_pkg::CSR_BLOCK_SIZE:  cfg_block_size = value[bba_pkg::BSIZE_W-1:0];
         bba_pkg::CSR_BLOCK_COUNT: cfg_block_count = value[bba_pkg::BCOUNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Stops offering beats and waits until every reply has come back.
   task automatic wait_drained(int settle);
      req_if.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Offers one request beat, then records the reply it is owed.
   task automatic send_req(logic op, logic [bba_pkg::SIZE_W-1:0] size,
                           logic [bba_pkg::ADDR_W-1:0] addr,
                           logic typed, alloc_reply_type want);
      alloc_reply_type predicted;
      while (sender_gaps && $urandom_range(99) < 21) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.opcode <= op;
      req_if.request_size <= size;
      req_if.free_address <= addr;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = predict_reply(op, size, addr);
      pending_replies.push_back(typed ? want : predicted);
      requests_sent++;
   endtask

   task automatic add_cfg(logic [bba_pkg::CSR_INDEX_W-1:0] idx,
                          logic [bba_pkg::CSR_DATA_W-1:0] value);
      script_row_type row;
      row = '{default: '0};
      row.is_write = 1'b1;
      row.reg_index = idx;
      row.reg_value = value;
      script.push_back(row);
   endtask

   task automatic add_req(logic op, logic [bba_pkg::SIZE_W-1:0] size,
                          logic [bba_pkg::ADDR_W-1:0] addr, logic typed,
                          logic [bba_pkg::ADDR_W-1:0] want_addr,
                          bba_pkg::status_type want_status);
      script_row_type row;
      row = '{default: '0};
      row.opcode = op;
      row.request_size = size;
      row.free_address = addr;
      row.typed = typed;
      row.reply.block_address = want_addr;
      row.reply.status = want_status;
      script.push_back(row);
   endtask

   // Writes all three registers, with junk above each field's width.
   task automatic set_pool(logic [bba_pkg::ADDR_W-1:0] base, int size, int count);
      write_reg(bba_pkg::CSR_POOL_BASE, base);
      write_reg(bba_pkg::CSR_BLOCK_SIZE,
                {$urandom_range(1) ? 19'($urandom()) : 19'd0, bba_pkg::BSIZE_W'(size)});
      write_reg(bba_pkg::CSR_BLOCK_COUNT,
                {$urandom_range(1) ? 24'($urandom()) : 24'd0, bba_pkg::BCOUNT_W'(count)});
      if ($urandom_range(3) == 0)
         write_reg(CSR_SPARE, $urandom());
      settings_seen++;
   endtask

   // One random request: mostly allocs of the right size and frees of held blocks.
   task automatic random_request();
      logic                       op;
      logic [bba_pkg::SIZE_W-1:0] size;
      logic [bba_pkg::ADDR_W-1:0] addr;
      logic [bba_pkg::ADDR_W-1:0] slack;
      logic [63:0]                extent;
      alloc_reply_type            none;
      int                         n;
      int                         live;
      int                         pick;
      n = active_blocks();
      live = 0;
      for (int i = 0; i < n; i++)
         if (block_taken[i]) live++;
      extent = 64'(cfg_block_size) * 64'(n);
      op = bba_pkg::OP_ALLOC;
      size = bba_pkg::SIZE_W'(cfg_block_size);
      addr = $urandom();
      none = '0;
      if ($urandom_range(99) < 14) begin
         // Malformed traffic: wrong sizes, stray addresses, pool edges, repeated frees.
         case ($urandom_range(3))
            0: size = bba_pkg::SIZE_W'($urandom());
            1: op = bba_pkg::OP_FREE;
            2: begin
               op = bba_pkg::OP_FREE;
               case ($urandom_range(3))
                  0: addr = cfg_base - 1;
                  1: addr = cfg_base;
                  2: addr = bba_pkg::ADDR_W'(64'(cfg_base) + extent);
                  default: addr = bba_pkg::ADDR_W'(64'(cfg_base) + extent - 1);
               endcase
            end
            default: begin
               op = bba_pkg::OP_FREE;
               if (n > 0)
                  addr = cfg_base + bba_pkg::ADDR_W'($urandom_range(n - 1)) *
                         bba_pkg::ADDR_W'(cfg_block_size);
            end
         endcase
      end else if (live > 0 && $urandom_range(99) < ((live * 2 > n) ? 65 : 35)) begin
         // Release a held block, anywhere inside it.
         op = bba_pkg::OP_FREE;
         pick = $urandom_range(live - 1);
         if (cfg_block_size > 1)
            slack = bba_pkg::ADDR_W'($urandom_range(cfg_block_size - 1));
         else
            slack = '0;
         for (int i = 0; i < n; i++) begin
            if (block_taken[i]) begin
               if (pick == 0)
                  addr = cfg_base + bba_pkg::ADDR_W'(i) * bba_pkg::ADDR_W'(cfg_block_size) +
                         slack;
               pick--;
            end
         end
      end
      if (op == bba_pkg::OP_FREE)
         size = bba_pkg::SIZE_W'($urandom());
      send_req(op, size, addr, 1'b0, none);
   endtask

   // Reply side: checks each beat and throttles ready.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("reply beat with nothing outstanding", rsp_if.block_address, 0);
            end else begin
               alloc_reply_type want;
               want = pending_replies.pop_front();
               if (rsp_if.block_address !== want.block_address)
                  report_mismatch("block_address", rsp_if.block_address, want.block_address);
               if (rsp_if.status !== want.status)
                  report_mismatch("status", rsp_if.status, want.status);
               if (want.status <= bba_pkg::ST_NOT_ALLOCATED)
                  status_tally[want.status]++;
            end
         end
         // A long hold-off, counted here once the sender asks for it.
         if (hold_start && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !receiver_stalls || ($urandom_range(99) >= 21);
         end
      end
   end

   // Stimulus.
   initial begin
      int items;
      req_if.valid = 1'b0;
      req_if.opcode = bba_pkg::OP_ALLOC;
      req_if.request_size = '0;
      req_if.free_address = '0;
      cfg_base = bba_pkg::RST_POOL_BASE;
      cfg_block_size = bba_pkg::RST_BLOCK_SIZE;
      cfg_block_count = bba_pkg::RST_BLOCK_COUNT;
      foreach (block_taken[i]) block_taken[i] = 1'b0;

      // Directed table, starting from the reset settings: base 0, size 8, 128 blocks.
      add_req(bba_pkg::OP_ALLOC, 16'd8, 32'h0, 1'b1, 32'd0, bba_pkg::ST_OK);
      add_req(bba_pkg::OP_ALLOC, 16'd8, 32'hFFFF_FFFF, 1'b1, 32'd8, bba_pkg::ST_OK);
      add_req(bba_pkg::OP_ALLOC, 16'hFFFF, 32'h0, 1'b1, 32'd0, bba_pkg::ST_SIZE_MISMATCH);
      add_req(bba_pkg::OP_ALLOC, 16'd0, 32'h0, 1'b1, 32'd0, bba_pkg::ST_SIZE_MISMATCH);
      add_req(bba_pkg::OP_FREE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, bba_pkg::ST_NOT_IN_POOL);
      // An address inside a block frees that block; a second free finds it clear.
      add_req(bba_pkg::OP_FREE, 16'd0, 32'd12, 1'b1, 32'd0, bba_pkg::ST_OK);
      add_req(bba_pkg::OP_FREE, 16'd0, 32'd12, 1'b1, 32'd0, bba_pkg::ST_NOT_ALLOCATED);
      // The upper pool bound is exclusive.
      add_req(bba_pkg::OP_FREE, 16'd0, 32'd1024, 1'b1, 32'd0, bba_pkg::ST_NOT_IN_POOL);
      add_req(bba_pkg::OP_FREE, 16'd0, 32'd1023, 1'b1, 32'd0, bba_pkg::ST_NOT_ALLOCATED);
      // A write to the unused index changes nothing.
      add_cfg(CSR_SPARE, 32'hFFFF_FFFF);
      add_req(bba_pkg::OP_ALLOC, 16'd8, 32'h0, 1'b1, 32'd8, bba_pkg::ST_OK);
      // Zero blocks: allocs are full, frees are outside.
      add_cfg(bba_pkg::CSR_BLOCK_COUNT, 32'd0);
      add_req(bba_pkg::OP_ALLOC, 16'd8, 32'h0, 1'b1, 32'd0, bba_pkg::ST_POOL_FULL);
      add_req(bba_pkg::OP_FREE, 16'd0, 32'd0, 1'b1, 32'd0, bba_pkg::ST_NOT_IN_POOL);
      add_cfg(bba_pkg::CSR_BLOCK_COUNT, 32'd2);
      add_req(bba_pkg::OP_ALLOC, 16'd8, 32'h0, 1'b1, 32'd0, bba_pkg::ST_POOL_FULL);
      // Zero block size, and a count above capacity.
      add_cfg(bba_pkg::CSR_BLOCK_SIZE, 32'd0);
      add_cfg(bba_pkg::CSR_BLOCK_COUNT, 32'd200);
      add_req(bba_pkg::OP_ALLOC, 16'd0, 32'h0, 1'b1, 32'd0, bba_pkg::ST_OK);
      add_req(bba_pkg::OP_FREE, 16'd0, 32'd0, 1'b1, 32'd0, bba_pkg::ST_NOT_IN_POOL);
      // Pool at the top of the address space: alloc addresses wrap, containment does not.
      add_cfg(bba_pkg::CSR_BLOCK_SIZE, 32'd4096);
      add_cfg(bba_pkg::CSR_POOL_BASE, 32'hFFFF_F000);
      add_cfg(bba_pkg::CSR_BLOCK_COUNT, 32'd5);
      add_req(bba_pkg::OP_ALLOC, 16'd4096, 32'h0, 1'b1, 32'h0000_2000, bba_pkg::ST_OK);
      add_req(bba_pkg::OP_FREE, 16'd0, 32'hFFFF_FFFF, 1'b1, 32'd0, bba_pkg::ST_OK);
      add_req(bba_pkg::OP_FREE, 16'd0, 32'h0000_0100, 1'b1, 32'd0, bba_pkg::ST_NOT_IN_POOL);
      add_req(bba_pkg::OP_ALLOC, 16'd4096, 32'h0, 1'b1, 32'hFFFF_F000, bba_pkg::ST_OK);
      // Largest block size with a full-size pool.
      add_cfg(bba_pkg::CSR_BLOCK_SIZE, 32'd8191);
      add_cfg(bba_pkg::CSR_POOL_BASE, 32'd0);
      add_cfg(bba_pkg::CSR_BLOCK_COUNT, 32'd128);
      add_req(bba_pkg::OP_ALLOC, 16'd8191, 32'h0, 1'b0, 32'd0, bba_pkg::ST_OK);
      add_req(bba_pkg::OP_FREE, 16'd0, 32'd40954, 1'b0, 32'd0, bba_pkg::ST_OK);
      add_req(bba_pkg::OP_FREE, 16'd0, 32'd1048447, 1'b1, 32'd0, bba_pkg::ST_NOT_ALLOCATED);
      add_req(bba_pkg::OP_FREE, 16'd0, 32'd1048448, 1'b1, 32'd0, bba_pkg::ST_NOT_IN_POOL);
      // Shrunk pool: held blocks above the count keep their bits until it grows again.
      add_cfg(bba_pkg::CSR_BLOCK_COUNT, 32'd1);
      add_req(bba_pkg::OP_ALLOC, 16'd8191, 32'h0, 1'b1, 32'd0, bba_pkg::ST_POOL_FULL);
      add_cfg(bba_pkg::CSR_BLOCK_COUNT, 32'd128);
      add_req(bba_pkg::OP_FREE, 16'd0, 32'd24573, 1'b1, 32'd0, bba_pkg::ST_OK);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r]) begin
         if (script[r].is_write) begin
            wait_drained(4);
            write_reg(script[r].reg_index, script[r].reg_value);
         end else begin
            send_req(script[r].opcode, script[r].request_size, script[r].free_address,
                     script[r].typed, script[r].reply);
         end
      end
      settings_seen++;

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 9; phase++) begin
         wait_drained(SETTLE_CYCLES);
         items = 220;
         case (phase)
            0: set_pool($urandom() & 32'h7FFF_FFF8, 8, 128);
            1: set_pool(32'd0, 1, 128);
            2: set_pool(32'hFFF8_0000, 4096, 128);
            3: set_pool($urandom() & 32'h0FFF_FFFF, $urandom_range(64, 1), $urandom_range(16, 1));
            4: begin
               set_pool($urandom(), 0, $urandom_range(8, 1));
               items = 60;
            end
            5: begin
               set_pool($urandom_range(4096, 0), $urandom_range(32, 1), 0);
               items = 40;
            end
            6: set_pool($urandom() & 32'h3FFF_FFFF, $urandom_range(512, 1),
                        $urandom_range(255, 129));
            7: set_pool($urandom(), $urandom_range(8191, 1), $urandom_range(128, 1));
            default: begin
               // Back to back, no idling on either side.
               set_pool(32'd0, 8, 128);
               sender_gaps = 1'b0;
               receiver_stalls = 1'b0;
            end
         endcase
         for (int k = 0; k < items; k++) begin
            // Reply side holds off while requests keep coming.
            if (phase == 2 && k == 40)
               hold_start = 1'b1;
            // Sender waits for every outstanding reply.
            if (phase == 3 && k == 100)
               wait_drained(0);
            random_request();
         end
      end

      wait_drained(SETTLE_CYCLES);
      $display("Covered %0d requests over %0d register settings, directed and random.",
               requests_sent, settings_seen);
      $display("Replies: ok %0d, size mismatch %0d, full %0d, not in pool %0d, %s %0d.",
               status_tally[bba_pkg::ST_OK], status_tally[bba_pkg::ST_SIZE_MISMATCH],
               status_tally[bba_pkg::ST_POOL_FULL], status_tally[bba_pkg::ST_NOT_IN_POOL],
               "not allocated", status_tally[bba_pkg::ST_NOT_ALLOCATED]);
      if (error_count == 0) begin
         $display("bitmap_block_allocator_top regression: pass");
      end else begin
         $display("bitmap_block_allocator_top regression: fail");
      end
      $finish;
   end

endmodule
